[sv/alc_pkg.sv]
// ----------------------------------------------------------------------------
// alc_pkg
// Shared widths, register indexes and coefficient tables for the lux pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package alc_pkg;

  // raw count and scaled channel widths
  localparam int CNT_W   = 16;
  localparam int SCALE_W = 19;
  localparam int PROD_W  = CNT_W + SCALE_W;
  localparam int CH_W    = 25;
  localparam int CH_SCALE  = 10;
  localparam int LUX_FRAC  = 14;

  // segment table shape
  localparam int SEGMENTS = 8;
  localparam int SEG_W    = 3;
  localparam int COEF_W   = 10;
  localparam int LIM_W    = COEF_W + 1;
  localparam int RHS_W    = CH_W + LIM_W;
  localparam int TERM_W   = CH_W + COEF_W;
  localparam int LUX_W    = 16;

  // configuration register indexes
  localparam logic [1:0] CFG_ITIME    = 2'd0;
  localparam logic [1:0] CFG_PKG_CS   = 2'd1;
  localparam logic [1:0] CFG_CLIP_THR = 2'd2;

  // integration time codes
  localparam logic [1:0] ITIME_13MS  = 2'd0;
  localparam logic [1:0] ITIME_101MS = 2'd1;
  localparam logic [1:0] ITIME_402MS = 2'd2;

  // channel scale per integration time
  localparam logic [14:0] SCALE_13MS  = 15'h7517;
  localparam logic [14:0] SCALE_101MS = 15'h0FE7;
  localparam logic [14:0] SCALE_402MS = 15'h0400;

  // result status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_CLIP = 1'b1;

  typedef logic [COEF_W-1:0] coef_t;

  // scaled channels after stage one
  typedef struct packed {
    logic [CH_W-1:0] ch0;
    logic [CH_W-1:0] ch1;
    logic            clip;
  } chan_t;

  // channels with the chosen segment
  typedef struct packed {
    chan_t            chan;
    logic [SEG_W-1:0] seg;
  } segd_t;

  // ratio breakpoints
  function automatic coef_t seg_k(input logic cs, input logic [SEG_W-1:0] idx);
    coef_t k;
    k = '0;
    if (cs) begin
      unique case (idx)
        3'd0: k = 10'h043;
        3'd1: k = 10'h085;
        3'd2: k = 10'h0c8;
        3'd3: k = 10'h10a;
        3'd4: k = 10'h14d;
        3'd5: k = 10'h19a;
        3'd6: k = 10'h29a;
        default: k = 10'h3ff;
      endcase
    end else begin
      unique case (idx)
        3'd0: k = 10'h040;
        3'd1: k = 10'h080;
        3'd2: k = 10'h0c0;
        3'd3: k = 10'h100;
        3'd4: k = 10'h138;
        3'd5: k = 10'h19a;
        3'd6: k = 10'h29a;
        default: k = 10'h3ff;
      endcase
    end
    return k;
  endfunction

  // broadband coefficient per segment
  function automatic coef_t seg_b(input logic cs, input logic [SEG_W-1:0] idx);
    coef_t b;
    b = '0;
    if (cs) begin
      unique case (idx)
        3'd0: b = 10'h204;
        3'd1: b = 10'h228;
        3'd2: b = 10'h253;
        3'd3: b = 10'h282;
        3'd4: b = 10'h177;
        3'd5: b = 10'h101;
        3'd6: b = 10'h037;
        default: b = 10'h000;
      endcase
    end else begin
      unique case (idx)
        3'd0: b = 10'h1f2;
        3'd1: b = 10'h214;
        3'd2: b = 10'h23f;
        3'd3: b = 10'h270;
        3'd4: b = 10'h16f;
        3'd5: b = 10'h0d2;
        3'd6: b = 10'h018;
        default: b = 10'h000;
      endcase
    end
    return b;
  endfunction

  // infrared coefficient per segment
  function automatic coef_t seg_m(input logic cs, input logic [SEG_W-1:0] idx);
    coef_t m;
    m = '0;
    if (cs) begin
      unique case (idx)
        3'd0: m = 10'h1ad;
        3'd1: m = 10'h2c1;
        3'd2: m = 10'h363;
        3'd3: m = 10'h3df;
        3'd4: m = 10'h1dd;
        3'd5: m = 10'h127;
        3'd6: m = 10'h02b;
        default: m = 10'h000;
      endcase
    end else begin
      unique case (idx)
        3'd0: m = 10'h1be;
        3'd1: m = 10'h2d1;
        3'd2: m = 10'h37b;
        3'd3: m = 10'h3fe;
        3'd4: m = 10'h1fc;
        3'd5: m = 10'h0fb;
        3'd6: m = 10'h012;
        default: m = 10'h000;
      endcase
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[sv/alc_if.sv]
// ----------------------------------------------------------------------------
// alc_if
// Valid/ready channels for raw readings and lux results.
// ----------------------------------------------------------------------------
`default_nettype none

interface alc_in_if;
  logic                     valid;
  logic                     ready;
  logic [alc_pkg::CNT_W-1:0] broadband_count;
  logic [alc_pkg::CNT_W-1:0] infrared_count;
  logic                     gain_high;

  modport source (output valid, output broadband_count, output infrared_count,
                  output gain_high, input ready);
  modport sink   (input valid, input broadband_count, input infrared_count,
                  input gain_high, output ready);
endinterface

interface alc_out_if;
  logic                     valid;
  logic                     ready;
  logic [alc_pkg::LUX_W-1:0] lux_value;
  logic                     result_status;

  modport source (output valid, output lux_value, output result_status, input ready);
  modport sink   (input valid, input lux_value, input result_status, output ready);
endinterface

`default_nettype wire

[sv/ambient_light_lux_calc.sv]
// ----------------------------------------------------------------------------
// ambient_light_lux_calc
// Integer lux from broadband and infrared counts, five-stage pipeline.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      word
//  in_ch     in   valid/ready    broadband_count, infrared_count, gain_high
//  out_ch    out  valid/ready    lux_value, result_status
//  cfg_*     in   cfg_we only    cfg_index, cfg_wdata
//
//  one word per cycle while out_ch.ready holds; each word passes every stage register
//  stages: count scaling, breakpoint products, segment select, coefficient
//  products, round and saturate; the multiplier stages set the clock
//  synchronous active-low reset clears valid bits and loads register defaults
//  each stage holds under back-pressure and empty stages fill in, so bubbles close
// ----------------------------------------------------------------------------
`default_nettype none

module ambient_light_lux_calc (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  alc_in_if.sink                          in_ch,
  alc_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [1:0]                 cfg_index,
  input  wire logic [alc_pkg::CNT_W-1:0]  cfg_wdata
);

  logic [1:0]                itime_r;
  logic                      pkg_cs_r;
  logic [alc_pkg::CNT_W-1:0] clip_thr_r;

  logic                      a_valid;
  logic                      a_ready;
  alc_pkg::chan_t            a_data;
  logic                      c_valid;
  logic                      c_ready;
  alc_pkg::segd_t            c_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      itime_r    <= alc_pkg::ITIME_402MS;
      pkg_cs_r   <= 1'b0;
      clip_thr_r <= 16'd65000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        alc_pkg::CFG_ITIME:    itime_r    <= cfg_wdata[1:0];
        alc_pkg::CFG_PKG_CS:   pkg_cs_r   <= cfg_wdata[0];
        alc_pkg::CFG_CLIP_THR: clip_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // scaling stage
  alc_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .itime    (itime_r),
    .clip_thr (clip_thr_r),
    .dn_valid (a_valid),
    .dn_ready (a_ready),
    .dn_data  (a_data)
  );

  // segment selection stages
  alc_seg u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .pkg_cs   (pkg_cs_r),
    .up_valid (a_valid),
    .up_ready (a_ready),
    .up_data  (a_data),
    .dn_valid (c_valid),
    .dn_ready (c_ready),
    .dn_data  (c_data)
  );

  // lux stages
  alc_lux u_lux (
    .clk      (clk),
    .rst_n    (rst_n),
    .pkg_cs   (pkg_cs_r),
    .up_valid (c_valid),
    .up_ready (c_ready),
    .up_data  (c_data),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

[sv/alc_scale.sv]
// ----------------------------------------------------------------------------
// alc_scale
// Stage one: clip detect and scaling of both counts for time and gain.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_scale (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  alc_in_if.sink                           in_ch,
  input  wire logic [1:0]                  itime,
  input  wire logic [alc_pkg::CNT_W-1:0]   clip_thr,
  output logic                             dn_valid,
  input  wire logic                        dn_ready,
  output alc_pkg::chan_t                   dn_data
);

  logic                         v_r;
  logic                         en;
  logic [14:0]                  scale_base;
  logic [alc_pkg::SCALE_W-1:0]  scale;
  logic [alc_pkg::PROD_W-1:0]   prod0;
  logic [alc_pkg::PROD_W-1:0]   prod1;
  alc_pkg::chan_t               data_nxt;
  alc_pkg::chan_t               data_r;

  // stage moves when empty or when downstream takes
  assign en          = !v_r || dn_ready;
  assign in_ch.ready = en;

  // scale for integration time, code 3 behaves as 402 ms
  always_comb begin
    unique case (itime)
      alc_pkg::ITIME_13MS:  scale_base = alc_pkg::SCALE_13MS;
      alc_pkg::ITIME_101MS: scale_base = alc_pkg::SCALE_101MS;
      default:              scale_base = alc_pkg::SCALE_402MS;
    endcase
  end

  // low gain needs 16x more scale
  assign scale = in_ch.gain_high ? {4'b0000, scale_base} : {scale_base, 4'b0000};

  assign prod0 = alc_pkg::PROD_W'(in_ch.broadband_count) * alc_pkg::PROD_W'(scale);
  assign prod1 = alc_pkg::PROD_W'(in_ch.infrared_count) * alc_pkg::PROD_W'(scale);

  always_comb begin
    data_nxt.ch0  = prod0[alc_pkg::CH_SCALE +: alc_pkg::CH_W];
    data_nxt.ch1  = prod1[alc_pkg::CH_SCALE +: alc_pkg::CH_W];
    data_nxt.clip = (in_ch.broadband_count > clip_thr) || (in_ch.infrared_count > clip_thr);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_ch.valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en && in_ch.valid) begin
      data_r <= data_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = data_r;

endmodule

`default_nettype wire

[sv/alc_seg.sv]
// ----------------------------------------------------------------------------
// alc_seg
// Stages two and three: ratio breakpoint products, then segment select.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_seg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pkg_cs,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire alc_pkg::chan_t  up_data,
  output logic                 dn_valid,
  input  wire logic            dn_ready,
  output alc_pkg::segd_t       dn_data
);

  localparam int NLIM = alc_pkg::SEGMENTS - 1;

  logic                        vb_r;
  logic                        vc_r;
  logic                        en_b;
  logic                        en_c;
  alc_pkg::chan_t              chan_b_r;
  logic [alc_pkg::RHS_W-1:0]   rhs_nxt [NLIM];
  logic [alc_pkg::RHS_W-1:0]   rhs_r   [NLIM];
  logic [alc_pkg::RHS_W-1:0]   lhs;
  logic [NLIM-1:0]             below;
  logic [alc_pkg::SEG_W-1:0]   seg_nxt;
  alc_pkg::segd_t              data_c_r;

  assign en_c     = !vc_r || dn_ready;
  assign en_b     = !vb_r || en_c;
  assign up_ready = en_b;

  // ratio q = floor(ch1*1024/ch0); rounded ratio <= k exactly when ch1*1024 < (2k+1)*ch0
  always_comb begin
    for (int i = 0; i < NLIM; i++) begin
      rhs_nxt[i] = alc_pkg::RHS_W'(up_data.ch0) *
                   alc_pkg::RHS_W'({alc_pkg::seg_k(pkg_cs, alc_pkg::SEG_W'(i)), 1'b1});
    end
  end

  // stage two registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en_b) begin
      vb_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && up_valid) begin
      chan_b_r <= up_data;
      rhs_r    <= rhs_nxt;
    end
  end

  // compare against each breakpoint
  assign lhs = {1'b0, chan_b_r.ch1, {alc_pkg::CH_SCALE{1'b0}}};

  always_comb begin
    for (int i = 0; i < NLIM; i++) begin
      below[i] = lhs < rhs_r[i];
    end
  end

  // first breakpoint not exceeded, zero broadband means ratio zero
  always_comb begin
    seg_nxt = alc_pkg::SEG_W'(NLIM);
    for (int i = NLIM - 1; i >= 0; i--) begin
      if (below[i]) begin
        seg_nxt = alc_pkg::SEG_W'(i);
      end
    end
    if (chan_b_r.ch0 == '0) begin
      seg_nxt = '0;
    end
  end

  // stage three registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en_c) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && vb_r) begin
      data_c_r.chan <= chan_b_r;
      data_c_r.seg  <= seg_nxt;
    end
  end

  assign dn_valid = vc_r;
  assign dn_data  = data_c_r;

endmodule

`default_nettype wire

[sv/alc_lux.sv]
// ----------------------------------------------------------------------------
// alc_lux
// Stages four and five: coefficient products, then difference, round, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module alc_lux (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            pkg_cs,
  input  wire logic            up_valid,
  output logic                 up_ready,
  input  wire alc_pkg::segd_t  up_data,
  alc_out_if.source            out_ch
);

  localparam int SUM_W = alc_pkg::TERM_W + 1;
  localparam int SHR_W = SUM_W - alc_pkg::LUX_FRAC;

  logic                         vd_r;
  logic                         ve_r;
  logic                         en_d;
  logic                         en_e;
  logic [alc_pkg::TERM_W-1:0]   pos_r;
  logic [alc_pkg::TERM_W-1:0]   neg_r;
  logic                         clip_d_r;
  logic [alc_pkg::TERM_W-1:0]   diff;
  logic [SUM_W-1:0]             rnd;
  logic [SHR_W-1:0]             shr;
  logic [alc_pkg::LUX_W-1:0]    lux_nxt;
  logic [alc_pkg::LUX_W-1:0]    lux_r;
  logic                         status_r;

  assign en_e     = !ve_r || out_ch.ready;
  assign en_d     = !vd_r || en_e;
  assign up_ready = en_d;

  // stage four: both coefficient products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en_d) begin
      vd_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_d && up_valid) begin
      pos_r    <= alc_pkg::TERM_W'(up_data.chan.ch0) *
                  alc_pkg::TERM_W'(alc_pkg::seg_b(pkg_cs, up_data.seg));
      neg_r    <= alc_pkg::TERM_W'(up_data.chan.ch1) *
                  alc_pkg::TERM_W'(alc_pkg::seg_m(pkg_cs, up_data.seg));
      clip_d_r <= up_data.chan.clip;
    end
  end

  // clamp at zero, round half up, saturate to 16 bits; a clipped reading gives zero
  assign diff = (pos_r > neg_r) ? (pos_r - neg_r) : '0;
  assign rnd  = SUM_W'(diff) + SUM_W'(1 << (alc_pkg::LUX_FRAC - 1));
  assign shr  = rnd[SUM_W-1:alc_pkg::LUX_FRAC];

  always_comb begin
    if (clip_d_r) begin
      lux_nxt = '0;
    end else if (shr[SHR_W-1:alc_pkg::LUX_W] != '0) begin
      lux_nxt = '1;
    end else begin
      lux_nxt = shr[alc_pkg::LUX_W-1:0];
    end
  end

  // stage five: output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en_e) begin
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_e && vd_r) begin
      lux_r    <= lux_nxt;
      status_r <= clip_d_r ? alc_pkg::STATUS_CLIP : alc_pkg::STATUS_OK;
    end
  end

  assign out_ch.valid         = ve_r;
  assign out_ch.lux_value     = lux_r;
  assign out_ch.result_status = status_r;

endmodule

`default_nettype wire
